/* design/assert_macros.svh */
// assertion helpers used by the record queue
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* design/phfe_pkg.sv */
package phfe_pkg;

  localparam int unsigned MaxTcpOptBytes = 32;
  localparam int unsigned MaxPauseEntries = 32;

  localparam logic [5:0] FldNone = 6'd63;

  localparam logic [7:0] ProtoTcp  = 8'h06;
  localparam logic [7:0] ProtoUdp  = 8'h11;
  localparam logic [7:0] ProtoCnp  = 8'hFF;
  localparam logic [7:0] ProtoPause = 8'hFE;
  localparam logic [7:0] ProtoAck  = 8'hFC;
  localparam logic [7:0] ProtoNack = 8'hFD;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StNotIpv4  = 2'd1;
  localparam logic [1:0] StBadTcp   = 2'd2;
  localparam logic [1:0] StLongList = 2'd3;

  localparam logic CfgLayers = 1'b0;
  localparam logic CfgBrief  = 1'b1;

  // one finished record
  typedef struct packed {
    logic [5:0]  field_id;
    logic [63:0] field_value;
    logic [5:0]  entry_index;
    logic        header_done;
    logic [7:0]  header_length;
    logic [1:0]  parse_status;
  } rec_t;

  function automatic logic [15:0] swap16(input logic [15:0] v);
    return {v[7:0], v[15:8]};
  endfunction

  function automatic logic [31:0] swap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

/* design/packet_header_field_extractor.sv */
// Packet header parser: one packet byte per cycle in while the queue is not
// full, one record out for each completed field and at the header's end. A
// record is registered in the queue, so it appears on the output ports in the
// cycle after its byte is accepted when the queue is empty, later while the
// consumer stalls; the byte walker is combinational. full rises when the
// four-entry queue fills, refusing a byte in that cycle even if a record pops.
module packet_header_field_extractor import phfe_pkg::*; #(
  parameter int unsigned MAX_TCP_OPTION_BYTES = MaxTcpOptBytes,
  parameter int unsigned MAX_PAUSE_ENTRIES = MaxPauseEntries
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_pkt_byte,
  input  logic        in_first_byte,
  output logic        empty,
  input  logic        pop,
  output logic [5:0]  out_field_id,
  output logic [63:0] out_field_value,
  output logic [5:0]  out_entry_index,
  output logic        out_header_done,
  output logic [7:0]  out_header_length,
  output logic [1:0]  out_parse_status
);
  logic rec_vld, q_full;
  rec_t rec, head;

  assign full = q_full;

  phfe_parser #(
    .MAX_TCP_OPTION_BYTES(MAX_TCP_OPTION_BYTES),
    .MAX_PAUSE_ENTRIES(MAX_PAUSE_ENTRIES)
  ) u_parser (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .byte_vld(push && !q_full), .pkt_byte(in_pkt_byte), .first_byte(in_first_byte),
    .rec_vld, .rec
  );

  phfe_fifo u_fifo (
    .clk, .rst_n, .wr(rec_vld), .wdata(rec), .full(q_full),
    .rd(pop), .empty, .rdata(head)
  );

  assign out_field_id = head.field_id;
  assign out_field_value = head.field_value;
  assign out_entry_index = head.entry_index;
  assign out_header_done = head.header_done;
  assign out_header_length = head.header_length;
  assign out_parse_status = head.parse_status;
endmodule

/* design/phfe_parser.sv */
// front part: walks the header a byte at a time and forms records
module phfe_parser import phfe_pkg::*; #(
  parameter int unsigned MAX_TCP_OPTION_BYTES = MaxTcpOptBytes,
  parameter int unsigned MAX_PAUSE_ENTRIES = MaxPauseEntries
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [2:0] cfg_data,
  input  logic       byte_vld,
  input  logic [7:0] pkt_byte,
  input  logic       first_byte,
  output logic       rec_vld,
  output rec_t       rec
);

  logic [2:0]  layers_r;
  logic        brief_r;
  logic [7:0]  off_r;
  logic [63:0] acc_r;
  logic [7:0]  proto_r;
  logic [5:0]  ihb_r;
  logic [15:0] tlen_r;
  logic [3:0]  doff_r;
  logic [15:0] pcnt_r;
  logic        fin_r;

  logic [7:0]  off_nxt, proto_nxt;
  logic [63:0] acc_nxt;
  logic [5:0]  ihb_nxt;
  logic [15:0] tlen_nxt, pcnt_nxt;
  logic [3:0]  doff_nxt;
  logic        fin_nxt;

  // working values, widened so sums never wrap
  logic [8:0]  o, n, l2, base, q;
  logic [8:0]  chk_n;
  logic        active, restart, cmpl, done;
  logic [1:0]  cst;
  logic [5:0]  id, idx;
  logic [63:0] val;
  logic [3:0]  ihl;
  logic [15:0] h;
  logic [31:0] w;
  logic        full;
  logic [17:0] want;
  logic [8:0]  c;
  logic        gate;

  // header completion over the updated state
  always_comb begin
    cmpl = 1'b0;
    cst = StOk;
    want = '0;
    gate = 1'b1;
    base = l2;
    if (layers_r[1]) begin
      if (chk_n <= l2) gate = 1'b0;
      base = l2 + {3'd0, ihb_nxt};
    end
    if (chk_n < base) gate = 1'b0;
    c = chk_n - base;
    if (layers_r[2]) begin
      if (proto_nxt == ProtoTcp) begin
        if (c < 9'd14) gate = 1'b0;
        if (brief_r) want = ({14'd0, doff_nxt} * 18'd4 < 18'd14) ? 18'd14
                            : {14'd0, doff_nxt} * 18'd4;
        else if (doff_nxt < 4'd5 ||
                 ({14'd0, doff_nxt} - 18'd5) * 18'd4 > 18'(MAX_TCP_OPTION_BYTES)) begin
          want = 18'd20;
          cst = StBadTcp;
        end else want = {14'd0, doff_nxt} * 18'd4;
      end else if (proto_nxt == ProtoUdp) want = 18'd30;
      else if (proto_nxt == ProtoCnp || proto_nxt == ProtoAck || proto_nxt == ProtoNack)
        want = 18'd8;
      else if (proto_nxt == ProtoPause) begin
        if (c < 9'd6) gate = 1'b0;
        if (pcnt_nxt > 16'(MAX_PAUSE_ENTRIES)) begin
          want = 18'd6;
          cst = StLongList;
        end else want = 18'd6 + {1'b0, pcnt_nxt, 1'b0};
      end
    end
    cmpl = gate && ({9'd0, c} >= want);
  end

  // per byte field extraction
  always_comb begin
    restart = byte_vld && first_byte;
    active = byte_vld && (first_byte || !fin_r);
    l2 = layers_r[0] ? 9'd2 : 9'd0;
    off_nxt = off_r; acc_nxt = acc_r; proto_nxt = proto_r; ihb_nxt = ihb_r;
    tlen_nxt = tlen_r; doff_nxt = doff_r; pcnt_nxt = pcnt_r; fin_nxt = fin_r;
    if (restart) begin
      off_nxt = '0; acc_nxt = '0; ihb_nxt = '0; tlen_nxt = '0;
      doff_nxt = '0; pcnt_nxt = '0; fin_nxt = 1'b0;
    end
    o = {1'b0, (restart ? 8'd0 : off_r)};
    n = o + 9'd1;
    id = FldNone; idx = '0; val = '0; done = 1'b0;
    full = !brief_r;
    q = '0; h = '0; w = '0; ihl = '0;
    chk_n = n;
    rec_vld = 1'b0;
    rec = '0;
    if (active) begin
      // empty header check on a restart, before the byte is consumed
      chk_n = 9'd0;
      if (restart && cmpl_zero()) begin
        fin_nxt = 1'b1;
        rec_vld = 1'b1;
        rec = '{FldNone, 64'd0, 6'd0, 1'b1, 8'd0, StOk};
      end else begin
        chk_n = n;
        off_nxt = n[7:0];
        acc_nxt = {(restart ? 56'd0 : acc_r[55:0]), pkt_byte};
        h = acc_nxt[15:0];
        w = acc_nxt[31:0];
        if (o < l2) begin
          if (o == 9'd1) begin id = 6'd0; val = {48'd0, h}; end
        end else if (layers_r[1] && (o == l2 || o - l2 < {3'd0, ihb_nxt})) begin
          q = o - l2;
          if (q == 9'd0) begin
            ihl = pkt_byte[3:0];
            ihb_nxt = (ihl < 4'd5) ? 6'd20 : {ihl, 2'b00};
          end else begin
            case (q)
              9'd1: begin id = 6'd1; val = {56'd0, pkt_byte}; end
              9'd3: if (full) begin
                tlen_nxt = h;
                id = 6'd2; val = {48'd0, h - {10'd0, ihb_nxt}};
              end
              9'd5: begin id = 6'd3; val = {48'd0, h}; end
              9'd6: if (full) begin id = 6'd4; val = {62'd0, pkt_byte[6:5]}; end
              9'd7: if (full) begin
                id = 6'd5; val = {48'd0, h[12:0], 3'd0};
              end
              9'd8: if (full) begin id = 6'd6; val = {56'd0, pkt_byte}; end
              9'd9: begin proto_nxt = pkt_byte; id = 6'd7; val = {56'd0, pkt_byte}; end
              9'd11: if (full) begin id = 6'd8; val = {48'd0, h}; end
              9'd15: begin id = 6'd9; val = {32'd0, w}; end
              9'd19: begin id = 6'd10; val = {32'd0, w}; end
              default: ;
            endcase
          end
        end else if (layers_r[2]) begin
          q = o - l2 - (layers_r[1] ? {3'd0, ihb_nxt} : 9'd0);
          if (proto_r == ProtoTcp) begin
            case (q)
              9'd1: begin id = 6'd11; val = {48'd0, h}; end
              9'd3: begin id = 6'd12; val = {48'd0, h}; end
              9'd7: begin id = 6'd13; val = {32'd0, w}; end
              9'd11: begin id = 6'd14; val = {32'd0, w}; end
              9'd13: begin doff_nxt = h[15:12]; id = 6'd15; val = {58'd0, h[5:0]}; end
              9'd15: if (full) begin id = 6'd16; val = {48'd0, h}; end
              9'd19: if (full) begin id = 6'd17; val = {48'd0, h}; end
              default: if (full && q >= 9'd20) begin
                id = 6'd18; val = {56'd0, pkt_byte}; idx = 6'(q - 9'd20);
              end
            endcase
          end else if (proto_r == ProtoUdp) begin
            case (q)
              9'd1: begin id = 6'd19; val = {48'd0, h}; end
              9'd3: begin id = 6'd20; val = {48'd0, h}; end
              9'd5: if (full) begin id = 6'd21; val = {48'd0, h}; end
              9'd11: begin id = 6'd22; val = {32'd0, w}; end
              9'd19: begin id = 6'd23; val = acc_nxt; end
              9'd21: begin id = 6'd24; val = {48'd0, h}; end
              9'd25: begin id = 6'd25; val = {32'd0, w}; end
              9'd29: begin id = 6'd26; val = {32'd0, w}; end
              default: ;
            endcase
          end else if (proto_r == ProtoCnp) begin
            case (q)
              9'd0: begin id = 6'd27; val = {56'd0, pkt_byte}; end
              9'd2: begin id = 6'd28; val = {48'd0, swap16(h)}; end
              9'd3: begin id = 6'd29; val = {56'd0, pkt_byte}; end
              9'd5: begin id = 6'd30; val = {48'd0, swap16(h)}; end
              9'd7: begin id = 6'd31; val = {48'd0, swap16(h)}; end
              default: ;
            endcase
          end else if (proto_r == ProtoAck || proto_r == ProtoNack) begin
            case (q)
              9'd1: begin id = 6'd32; val = {48'd0, swap16(h)}; end
              9'd5: begin id = 6'd33; val = {32'd0, swap32(w)}; end
              9'd7: begin id = 6'd34; val = {48'd0, swap16(h)}; end
              default: ;
            endcase
          end else if (proto_r == ProtoPause) begin
            if (q == 9'd3) begin id = 6'd35; val = {32'd0, swap32(w)}; end
            else if (q == 9'd5) begin
              pcnt_nxt = swap16(h); id = 6'd36; val = {48'd0, swap16(h)};
            end else if (q >= 9'd6 && q[0] == 1'b1) begin
              id = 6'd37; val = {48'd0, h}; idx = 6'((q - 9'd6) >> 1);
            end
          end
        end
        // bad version stops at once
        if (layers_r[1] && !(o < l2) && o == l2 && pkt_byte[7:4] != 4'd4) begin
          fin_nxt = 1'b1;
          rec_vld = 1'b1;
          rec = '{FldNone, 64'd0, 6'd0, 1'b1, 8'd0, StNotIpv4};
          ihb_nxt = ihb_r;
          if (restart) ihb_nxt = '0;
        end else begin
          done = cmpl;
          if (done) fin_nxt = 1'b1;
          rec_vld = (id != FldNone) || done;
          rec = '{id, (id == FldNone) ? 64'd0 : val, idx, done,
                  done ? n[7:0] : 8'd0, done ? cst : StOk};
        end
      end
    end
  end

  // completion at zero consumed bytes: uses reset values of the walk
  function automatic logic cmpl_zero();
    logic [8:0] lb;
    lb = layers_r[0] ? 9'd2 : 9'd0;
    if (layers_r[1]) return 1'b0;
    if (!layers_r[2]) return lb == 9'd0;
    if (lb != 9'd0) return 1'b0;
    if (proto_r == ProtoTcp || proto_r == ProtoUdp || proto_r == ProtoCnp ||
        proto_r == ProtoAck || proto_r == ProtoNack || proto_r == ProtoPause)
      return 1'b0;
    return 1'b1;
  endfunction

  // state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layers_r <= 3'd6; brief_r <= 1'b1; off_r <= '0; acc_r <= '0;
      proto_r <= '0; ihb_r <= '0; tlen_r <= '0; doff_r <= '0;
      pcnt_r <= '0; fin_r <= 1'b1;
    end else begin
      if (cfg_we && cfg_index == CfgLayers) layers_r <= cfg_data;
      if (cfg_we && cfg_index == CfgBrief) brief_r <= cfg_data[0];
      off_r <= off_nxt; acc_r <= acc_nxt; proto_r <= proto_nxt;
      ihb_r <= ihb_nxt; tlen_r <= tlen_nxt; doff_r <= doff_nxt;
      pcnt_r <= pcnt_nxt; fin_r <= fin_nxt;
    end
  end

endmodule

/* design/phfe_fifo.sv */
// back part: short record queue toward the consumer
module phfe_fifo import phfe_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr,
  input  rec_t wdata,
  output logic full,
  input  logic rd,
  output logic empty,
  output rec_t rdata
);
  `include "assert_macros.svh"

  rec_t       mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       do_wr, do_rd;

  assign full  = cnt_r == 3'd4;
  assign empty = cnt_r == 3'd0;
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem_r[rp_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wdata;
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= wp_r + 2'd1;
      if (do_rd) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'd0, do_wr} - {2'd0, do_rd};
    end
  end

  `ASSERT_CLK(a_cnt_range, clk, rst_n, cnt_r <= 3'd4, "queue count overflow")
  `ASSERT_CLK(a_ptr_gap, clk, rst_n, (wp_r - rp_r) == cnt_r[1:0], "pointer gap mismatch")
  `ASSERT_CLK(a_rd_step, clk, rst_n, do_rd && !do_wr |=> cnt_r == $past(cnt_r) - 3'd1, "bad pop")
  `ASSERT_NEVER(a_no_drop, clk, rst_n, wr && full, "record written while queue full")
endmodule

/* verif/phfe_checker.sv */
`timescale 1ns / 1ps

// watches both channels and the register port, predicts every record
// and compares it with what the block delivers
module phfe_checker import phfe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_data,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  in_pkt_byte,
  input  logic        in_first_byte,
  input  logic        empty,
  input  logic        pop,
  input  logic [5:0]  out_field_id,
  input  logic [63:0] out_field_value,
  input  logic [5:0]  out_entry_index,
  input  logic        out_header_done,
  input  logic [7:0]  out_header_length,
  input  logic [1:0]  out_parse_status,
  output int          mismatches,
  output int          records_pending
);

  // predictor copy of the registers and the parse state
  logic [2:0]  layers;
  logic        brief;
  int unsigned offset;
  logic [63:0] acc;
  logic [7:0]  proto;
  int unsigned ip_hdr_bytes;
  int unsigned ip_tot_len;
  int unsigned tcp_doff;
  int unsigned pause_cnt;
  bit          idle;

  rec_t expected_records[$];

  assign records_pending = expected_records.size();

  // is the header complete after n consumed bytes
  function automatic bit header_ends(input int unsigned n, output int unsigned len,
                                     output int unsigned st);
    int unsigned l2, base, c, want, st_l;
    l2 = layers[0] ? 2 : 0;
    base = l2;
    want = 0;
    st_l = 32'(StOk);
    len = 0;
    st = 0;
    if (layers[1]) begin
      if (n <= l2) return 0;
      base += ip_hdr_bytes;
    end
    if (n < base) return 0;
    c = n - base;
    if (layers[2]) begin
      if (proto == ProtoTcp) begin
        if (c < 14) return 0;
        if (brief) want = (tcp_doff * 4 < 14) ? 14 : tcp_doff * 4;
        else if (tcp_doff < 5 || (tcp_doff - 5) * 4 > MaxTcpOptBytes) begin
          want = 20;
          st_l = 32'(StBadTcp);
        end else want = tcp_doff * 4;
      end else if (proto == ProtoUdp) begin
        want = 30;
      end else if (proto == ProtoCnp || proto == ProtoAck || proto == ProtoNack) begin
        want = 8;
      end else if (proto == ProtoPause) begin
        if (c < 6) return 0;
        if (pause_cnt > MaxPauseEntries) begin
          want = 6;
          st_l = 32'(StLongList);
        end else want = 6 + 2 * pause_cnt;
      end
    end
    if (c < want) return 0;
    len = n & 32'hFF;
    st = st_l;
    return 1;
  endfunction

  // advance the parse by one accepted byte, maybe producing a record
  function automatic bit predict_record(input logic [7:0] b, input logic first,
                                        output rec_t rec);
    int unsigned o, n, l2, r, q, ih, len, st;
    logic [5:0]  id;
    logic [63:0] val;
    logic [5:0]  idx;
    logic [15:0] h;
    logic [31:0] w;
    bit          done, full_mode;
    id = FldNone;
    val = '0;
    idx = '0;
    len = 0;
    st = 0;
    rec = '0;
    full_mode = !brief;
    if (first) begin
      offset = 0;
      acc = '0;
      ip_hdr_bytes = 0;
      ip_tot_len = 0;
      tcp_doff = 0;
      pause_cnt = 0;
      idle = 0;
      if (header_ends(0, len, st)) begin
        idle = 1;
        rec = '{FldNone, 64'd0, 6'd0, 1'b1, len[7:0], st[1:0]};
        return 1;
      end
    end else if (idle) begin
      return 0;
    end
    o = offset;
    n = o + 1;
    offset = n & 32'hFF;
    acc = {acc[55:0], b};
    h = acc[15:0];
    w = acc[31:0];
    l2 = layers[0] ? 2 : 0;
    if (o < l2) begin
      // ppp protocol field
      if (o == 1) begin
        id = 6'd0;
        val = 64'(h);
      end
    end else if (layers[1] && (o == l2 || o - l2 < ip_hdr_bytes)) begin
      r = o - l2;
      if (r == 0) begin
        ih = 32'(b[3:0]) * 4;
        if (b[7:4] != 4'd4) begin
          idle = 1;
          rec = '{FldNone, 64'd0, 6'd0, 1'b1, 8'd0, StNotIpv4};
          return 1;
        end
        ip_hdr_bytes = (ih < 20) ? 20 : ih;
      end else begin
        case (r)
          1: begin id = 6'd1; val = 64'(b); end
          3: if (full_mode) begin
            ip_tot_len = 32'(h);
            id = 6'd2;
            val = 64'((ip_tot_len - ip_hdr_bytes) & 32'hFFFF);
          end
          5: begin id = 6'd3; val = 64'(h); end
          6: if (full_mode) begin id = 6'd4; val = 64'(b[6:5]); end
          7: if (full_mode) begin id = 6'd5; val = 64'({acc[12:8], acc[7:0]}) << 3; end
          8: if (full_mode) begin id = 6'd6; val = 64'(b); end
          9: begin proto = b; id = 6'd7; val = 64'(b); end
          11: if (full_mode) begin id = 6'd8; val = 64'(h); end
          15: begin id = 6'd9; val = 64'(w); end
          19: begin id = 6'd10; val = 64'(w); end
          default: ;
        endcase
      end
    end else if (layers[2]) begin
      q = o - (l2 + (layers[1] ? ip_hdr_bytes : 0));
      if (proto == ProtoTcp) begin
        case (q)
          1: begin id = 6'd11; val = 64'(h); end
          3: begin id = 6'd12; val = 64'(h); end
          7: begin id = 6'd13; val = 64'(w); end
          11: begin id = 6'd14; val = 64'(w); end
          13: begin tcp_doff = 32'(h[15:12]); id = 6'd15; val = 64'(h[5:0]); end
          15: if (full_mode) begin id = 6'd16; val = 64'(h); end
          19: if (full_mode) begin id = 6'd17; val = 64'(h); end
          default: if (full_mode && q >= 20) begin
            id = 6'd18;
            val = 64'(b);
            idx = 6'(q - 20);
          end
        endcase
      end else if (proto == ProtoUdp) begin
        case (q)
          1: begin id = 6'd19; val = 64'(h); end
          3: begin id = 6'd20; val = 64'(h); end
          5: if (full_mode) begin id = 6'd21; val = 64'(h); end
          11: begin id = 6'd22; val = 64'(w); end
          19: begin id = 6'd23; val = acc; end
          21: begin id = 6'd24; val = 64'(h); end
          25: begin id = 6'd25; val = 64'(w); end
          29: begin id = 6'd26; val = 64'(w); end
          default: ;
        endcase
      end else if (proto == ProtoCnp) begin
        case (q)
          0: begin id = 6'd27; val = 64'(b); end
          2: begin id = 6'd28; val = 64'(swap16(h)); end
          3: begin id = 6'd29; val = 64'(b); end
          5: begin id = 6'd30; val = 64'(swap16(h)); end
          7: begin id = 6'd31; val = 64'(swap16(h)); end
          default: ;
        endcase
      end else if (proto == ProtoAck || proto == ProtoNack) begin
        case (q)
          1: begin id = 6'd32; val = 64'(swap16(h)); end
          5: begin id = 6'd33; val = 64'(swap32(w)); end
          7: begin id = 6'd34; val = 64'(swap16(h)); end
          default: ;
        endcase
      end else if (proto == ProtoPause) begin
        if (q == 3) begin
          id = 6'd35;
          val = 64'(swap32(w));
        end else if (q == 5) begin
          pause_cnt = 32'(swap16(h));
          id = 6'd36;
          val = 64'(pause_cnt);
        end else if (q >= 6 && ((q - 6) & 1)) begin
          id = 6'd37;
          val = 64'(h);
          idx = 6'((q - 6) >> 1);
        end
      end
    end
    done = header_ends(n, len, st);
    if (done) idle = 1;
    if (id == FldNone && !done) return 0;
    if (id == FldNone) val = '0;
    rec = '{id, val, idx, done, done ? len[7:0] : 8'd0, done ? st[1:0] : StOk};
    return 1;
  endfunction

  // sample both channels at the clock edge
  always @(posedge clk) begin
    rec_t exp_rec, got;
    bit   has;
    if (!rst_n) begin
      layers <= 3'd6;
      brief <= 1'b1;
      offset = 0;
      acc = '0;
      proto = '0;
      ip_hdr_bytes = 0;
      ip_tot_len = 0;
      tcp_doff = 0;
      pause_cnt = 0;
      idle = 1;
      expected_records.delete();
      mismatches <= 0;
    end else begin
      if (push && !full) begin
        has = predict_record(in_pkt_byte, in_first_byte, exp_rec);
        if (has) expected_records.push_back(exp_rec);
      end
      if (pop && !empty) begin
        got = '{out_field_id, out_field_value, out_entry_index, out_header_done,
                out_header_length, out_parse_status};
        if (expected_records.size() == 0) begin
          if (mismatches < 10) $display("%0t: unexpected record %p", $realtime, got);
          mismatches <= mismatches + 1;
        end else begin
          exp_rec = expected_records.pop_front();
          if (got !== exp_rec) begin
            if (mismatches < 10)
              $display("%0t: record mismatch\n  expected %p\n  actual   %p",
                       $realtime, exp_rec, got);
            mismatches <= mismatches + 1;
          end
        end
      end
      // register writes take effect for the next request
      if (cfg_we) begin
        if (cfg_index == CfgLayers) layers <= cfg_data;
        else brief <= cfg_data[0];
      end
    end
  end

endmodule

/* verif/tb_packet_header_field_extractor.sv */
`timescale 1ns / 1ps

module tb_packet_header_field_extractor import phfe_pkg::*;;

  localparam int TargetBytes = 1700;
  localparam int StallLimit = 4000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [2:0]  cfg_data;
  logic        push;
  logic        full;
  logic [7:0]  in_pkt_byte;
  logic        in_first_byte;
  logic        empty;
  logic        pop;
  logic [5:0]  out_field_id;
  logic [63:0] out_field_value;
  logic [5:0]  out_entry_index;
  logic        out_header_done;
  logic [7:0]  out_header_length;
  logic [1:0]  out_parse_status;
  int          mismatches;
  int          records_pending;

  int          bytes_sent;
  int          burst_left;
  logic [2:0]  cur_layers;
  logic [7:0]  last_proto;
  logic [7:0]  pkt[$];

  packet_header_field_extractor u_dut (.*);

  phfe_checker u_checker (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // receiver: stall mode is redrawn at random from a free-running cycle counter, mode 0 never stalls
  int unsigned pop_cycle;
  int unsigned pop_mode;
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
      pop_cycle <= 0;
      pop_mode <= 0;
    end else begin
      pop_cycle <= pop_cycle + 1;
      if (pop_cycle % 64 == 0) pop_mode <= $urandom_range(0, 3);
      case (pop_mode)
        0: pop <= 1'b1;
        1: pop <= ($urandom_range(0, 3) != 0);
        2: pop <= ($urandom_range(0, 3) == 0);
        default: pop <= pop_cycle[3];
      endcase
    end
  end

  // watchdog on cycles with no transfer on either side
  int idle_cycles;
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one byte request, held until accepted; bursts with random gaps
  task automatic send_byte(input logic [7:0] b, input logic first);
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 12);
    end
    in_pkt_byte <= b;
    in_first_byte <= first;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    burst_left--;
  endtask

  task automatic send_packet(input bit count_it);
    foreach (pkt[i]) begin
      send_byte(pkt[i], i == 0);
      if (count_it) bytes_sent++;
    end
  endtask

  // register write only once every record has drained
  task automatic write_cfg(input logic idx, input logic [2:0] data);
    push <= 1'b0;
    @(posedge clk);
    while (records_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgLayers) cur_layers = data;
  endtask

  function automatic logic [7:0] pick_proto();
    case ($urandom_range(0, 6))
      0: return ProtoTcp;
      1: return ProtoUdp;
      2: return ProtoCnp;
      3: return ProtoPause;
      4: return ProtoAck;
      5: return ProtoNack;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // build a header for the current layers with random content
  task automatic build_packet();
    int unsigned ihl, ihb, doff, cnt, l4_len;
    pkt.delete();
    if (cur_layers[0]) repeat (2) pkt.push_back(8'($urandom_range(0, 255)));
    if (cur_layers[1]) begin
      ihl = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(5, 7);
      ihb = (ihl < 5) ? 20 : ihl * 4;
      if ($urandom_range(0, 15) == 0) pkt.push_back(8'($urandom_range(0, 255)));
      else pkt.push_back({4'd4, ihl[3:0]});
      last_proto = pick_proto();
      for (int r = 1; r < ihb; r++)
        pkt.push_back(r == 9 ? last_proto : 8'($urandom_range(0, 255)));
    end
    if (cur_layers[2]) begin
      l4_len = 0;
      if (last_proto == ProtoTcp) begin
        doff = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(5, 13);
        l4_len = (doff < 5) ? 20 : doff * 4;
        for (int q = 0; q < l4_len; q++)
          pkt.push_back(q == 12 ? {doff[3:0], 4'($urandom_range(0, 15))}
                                : 8'($urandom_range(0, 255)));
      end else if (last_proto == ProtoUdp) begin
        repeat (30) pkt.push_back(8'($urandom_range(0, 255)));
      end else if (last_proto == ProtoPause) begin
        cnt = ($urandom_range(0, 5) == 0) ? $urandom_range(33, 40) : $urandom_range(0, 32);
        repeat (4) pkt.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0) begin
          pkt.push_back(8'($urandom_range(0, 255)));
          pkt.push_back(8'($urandom_range(0, 255)));
        end else begin
          pkt.push_back(cnt[7:0]);
          pkt.push_back(8'd0);
        end
        repeat (2 * cnt) pkt.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat (8) pkt.push_back(8'($urandom_range(0, 255)));
      end
    end
    // trailing bytes, or a cut-short header
    repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom_range(0, 255)));
    if (pkt.size() > 1 && $urandom_range(0, 9) == 0)
      pkt = pkt[0:$urandom_range(0, pkt.size() - 1)];
    if (pkt.size() == 0) pkt.push_back(8'($urandom_range(0, 255)));
  endtask

  initial begin
    int phase;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CfgLayers;
    cfg_data = '0;
    push = 1'b0;
    in_pkt_byte = '0;
    in_first_byte = 1'b0;
    bytes_sent = 0;
    burst_left = 0;
    cur_layers = 3'd6;
    last_proto = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, stray byte while idle, not ipv4, short ihl
    pkt = '{8'hA5};
    send_byte(8'hA5, 1'b0);
    pkt = '{8'h65, 8'h00};
    send_packet(1);
    pkt = '{8'h41, 8'h00, 8'h00, 8'h14, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h7B};
    send_packet(1);
    // empty header and all layers at the extremes
    write_cfg(CfgLayers, 3'd0);
    pkt = '{8'hFF};
    send_packet(1);
    pkt = '{8'h00};
    send_packet(1);
    write_cfg(CfgLayers, 3'd7);
    write_cfg(CfgBrief, 3'd0);
    build_packet();
    send_packet(1);

    // random phases over all settings
    phase = 0;
    while (bytes_sent < TargetBytes) begin
      if (phase < 16) begin
        write_cfg(CfgLayers, 3'(phase % 8));
        write_cfg(CfgBrief, 3'(phase / 8));
      end else begin
        write_cfg(CfgLayers, ($urandom_range(0, 2) != 0) ? 3'd7 : 3'($urandom_range(0, 7)));
        write_cfg(CfgBrief, 3'($urandom_range(0, 1)));
      end
      repeat ($urandom_range(3, 8)) begin
        build_packet();
        send_packet(1);
        if ($urandom_range(0, 7) == 0) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      phase++;
    end

    push <= 1'b0;
    @(posedge clk);
    while (records_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && records_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/phfe_pkg.sv
design/phfe_parser.sv
design/phfe_fifo.sv
design/packet_header_field_extractor.sv
verif/phfe_checker.sv
verif/tb_packet_header_field_extractor.sv
